// ===== rtl/core/oog_pkg.sv =====
// Shared types and constants of the octant occupancy grid.
// Used by the grid top level and its mask memory; depends on nothing else.
package oog_pkg;

  localparam int OOG_MAX_DIM       = 64;
  localparam int OOG_POS_FRAC_BITS = 16;

  localparam int OPCODE_W   = 3;
  localparam int POS_W      = 32;
  localparam int IDX_W      = 7;
  localparam int SIZE_W     = 7;
  localparam int INV_W      = 32;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Fraction bits of the reciprocal of half the cell size (Q16.16).
  localparam int INV_FRAC_BITS = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
  localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(65536);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_MARK_POS  = 3'd1,
    OP_TEST_SUB  = 3'd2,
    OP_TEST_POS  = 3'd3,
    OP_READ_MASK = 3'd4
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_I   = 2'd0,
    REG_SIZE_J   = 2'd1,
    REG_SIZE_K   = 2'd2,
    REG_INV_HALF = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    pos_z;
    logic [IDX_W-1:0]    idx_i;
    logic [IDX_W-1:0]    idx_j;
    logic [IDX_W-1:0]    idx_k;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] cell_mask;
    logic              subcell_set;
    logic              out_of_range;
  } out_item_t;

endpackage

// ===== rtl/core/octant_occupancy_grid_unit.sv =====
// Top level of the octant occupancy grid: command sequencer, shared position
// multiplier and read-modify-write path. Depends on oog_pkg and oog_mask_ram.
//
// Usage. A command item is taken at a rising edge where start is high and busy
// is low. Its result is shown on res_o and marked by res_strobe_o for exactly
// one cycle; the receiver cannot stall, so every result must be captured in
// that cycle. The block takes the next item during the cycle its previous
// result is shown.
// Sequence of each command, from acceptance until the next item can be taken:
//   - read mask and test by sub-cell index: address, memory read, data,
//     result, with the result strobe in the last of these steps;
//   - mark and test by position: one 32x32 multiplier is shared by the
//     three axes, one axis per cycle, before the same 4 steps;
//   - out of range: after the address step the result follows and the memory is not touched;
//   - unused opcodes: the result (all zero) follows at once;
//   - clear: one mask byte written per cycle over all MAX_DIM^3 cells through
//     the single memory port, then the all-zero result.
// Reset starts the same clearing pass over all MAX_DIM^3 cells with busy
// high and no result strobe. Configuration writes are taken in every cycle,
// the clearing pass included, and must only be issued while no item is in
// flight.
// Each mark is a read-modify-write of one byte; items do not overlap, so a
// read never meets a pending write to the same cell.
module octant_occupancy_grid_unit import oog_pkg::*; #(
  parameter int MAX_DIM       = OOG_MAX_DIM,
  parameter int POS_FRAC_BITS = OOG_POS_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_i,
  output logic                  res_strobe_o,
  output out_item_t             res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_DIM);
  localparam int LW_RAW = $clog2(2 * MAX_DIM + 1);
  // Sub-index width: holds twice the largest size, and never narrower than
  // an index field plus one bit.
  localparam int LW     = (LW_RAW < IDX_W + 1) ? IDX_W + 1 : LW_RAW;
  localparam int SHIFT  = POS_FRAC_BITS + INV_FRAC_BITS;
  localparam int PW     = 2 * POS_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  // Control state.
  logic [2:0]        state_q, state_d;
  logic [1:0]        axis_q, axis_d;
  logic [AW-1:0]     clr_ptr_q, clr_ptr_d;
  logic              clr_resp_q, clr_resp_d;
  logic              res_strobe_q, res_strobe_d;

  // Configuration registers.
  logic [SIZE_W-1:0] size_q [3];
  logic [INV_W-1:0]  inv_q;

  // Item payload.
  in_item_t          in_q, in_d;
  logic [LW-1:0]     sub_q [3];
  logic [LW-1:0]     sub_d [3];
  logic [2:0]        big_q, big_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [MASK_W-1:0] bit_q, bit_d;
  out_item_t         res_q, res_d;

  // Datapath helpers.
  logic [POS_W-1:0]  mul_a;
  logic [PW-1:0]     prod;
  logic [LW-1:0]     eff [3];
  logic [LW-1:0]     lim [3];
  logic [CW-1:0]     cell_idx [3];
  logic              in_rng;
  logic              is_rd;
  logic [AW-1:0]     addr_calc;

  // Memory port.
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [MASK_W-1:0] ram_wdata, ram_rdata;

  assign busy         = (state_q != ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // One shared multiplier: the position of the current axis times the
  // reciprocal half-cell size, kept exact in 64 bits.
  always_comb begin
    case (axis_q)
      2'd0:    mul_a = in_q.pos_x;
      2'd1:    mul_a = in_q.pos_y;
      default: mul_a = in_q.pos_z;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(inv_q);

  // Range check and cell address. Read mask uses the index as a cell index
  // with limit size; every other command uses a sub-cell index with limit
  // twice the size, its low bit picking the octant.
  assign is_rd = (in_q.opcode == OP_READ_MASK);

  always_comb begin
    in_rng = 1'b1;
    for (int a = 0; a < 3; a++) begin
      eff[a]  = (LW'(size_q[a]) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(size_q[a]);
      lim[a]  = is_rd ? eff[a] : (eff[a] << 1);
      cell_idx[a] = is_rd ? sub_q[a][CW-1:0] : sub_q[a][CW:1];
      if (big_q[a] || (sub_q[a] >= lim[a])) begin
        in_rng = 1'b0;
      end
    end
    addr_calc = (AW'(cell_idx[0]) * AW'(MAX_DIM) + AW'(cell_idx[1])) * AW'(MAX_DIM)
              + AW'(cell_idx[2]);
  end

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    clr_ptr_d    = clr_ptr_q;
    clr_resp_d   = clr_resp_q;
    res_strobe_d = 1'b0;
    in_d         = in_q;
    sub_d        = sub_q;
    big_d        = big_q;
    addr_d       = addr_q;
    bit_d        = bit_q;
    res_d        = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          in_d  = in_i;
          res_d = '0;
          case (in_i.opcode) inside
            OP_CLEAR: begin
              clr_ptr_d  = '0;
              clr_resp_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            OP_MARK_POS, OP_TEST_POS: begin
              axis_d  = 2'd0;
              state_d = ST_MUL;
            end
            OP_TEST_SUB, OP_READ_MASK: begin
              sub_d[0] = LW'(in_i.idx_i);
              sub_d[1] = LW'(in_i.idx_j);
              sub_d[2] = LW'(in_i.idx_k);
              big_d    = '0;
              state_d  = ST_ADDR;
            end
            default: begin
              // Unused opcode: nothing is done, the all-zero result follows.
              res_strobe_d = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        sub_d[axis_q] = prod[SHIFT +: LW];
        big_d[axis_q] = ((prod >> (SHIFT + LW)) != '0);
        if (axis_q == 2'd2) begin
          state_d = ST_ADDR;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_ADDR: begin
        addr_d = addr_calc;
        bit_d  = MASK_W'(1) << {sub_q[2][0], sub_q[1][0], sub_q[0][0]};
        if (in_rng) begin
          state_d = ST_READ;
        end else begin
          res_d.out_of_range = 1'b1;
          res_strobe_d       = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_DATA;
      end
      ST_DATA: begin
        case (in_q.opcode) inside
          OP_READ_MASK:             res_d.cell_mask   = ram_rdata;
          OP_TEST_SUB, OP_TEST_POS: res_d.subcell_set = |(ram_rdata & bit_q);
          default:                  res_d             = '0;
        endcase
        res_strobe_d = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_ptr_q == AW'(DEPTH - 1)) begin
          clr_ptr_d    = '0;
          res_d        = '0;
          res_strobe_d = clr_resp_q;
          clr_resp_d   = 1'b0;
          state_d      = ST_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory access: the sweep writes zeros, a mark writes back the read byte
  // with its octant bit set, and the read step fetches the addressed byte.
  assign ram_we    = (state_q == ST_CLEAR) ||
                     ((state_q == ST_DATA) && (in_q.opcode == OP_MARK_POS));
  assign ram_en    = ram_we || (state_q == ST_READ);
  assign ram_addr  = (state_q == ST_CLEAR) ? clr_ptr_q : addr_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : (ram_rdata | bit_q);

  oog_mask_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      axis_q       <= 2'd0;
      clr_ptr_q    <= '0;
      clr_resp_q   <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      axis_q       <= axis_d;
      clr_ptr_q    <= clr_ptr_d;
      clr_resp_q   <= clr_resp_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SIZE_RESET;
      size_q[1] <= SIZE_RESET;
      size_q[2] <= SIZE_RESET;
      inv_q     <= INV_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SIZE_I:   size_q[0] <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_J:   size_q[1] <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_K:   size_q[2] <= cfg_data_i[SIZE_W-1:0];
        REG_INV_HALF: inv_q     <= cfg_data_i[INV_W-1:0];
        default:      inv_q     <= inv_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    sub_q  <= sub_d;
    big_q  <= big_d;
    addr_q <= addr_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

  // An out-of-range result never carries a mask or a set bit.
  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.out_of_range) |->
      (res_o.cell_mask == '0 && !res_o.subcell_set))
    else $error("out-of-range result carries data");

  // The memory is only written by the sweep or by the write-back of a mark.
  a_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_CLEAR) ||
                (state_q == ST_DATA && in_q.opcode == OP_MARK_POS)))
    else $error("unexpected memory write");

  // The sweep ends with the pointer back at zero and the block idle.
  a_clr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_ptr_q == AW'(DEPTH - 1)) |=>
      (clr_ptr_q == '0 && state_q == ST_IDLE))
    else $error("clear sweep did not finish cleanly");

  // An accepted item either occupies the sequencer or answers at once.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_strobe_o))
    else $error("accepted item was dropped");

endmodule

// ===== rtl/core/oog_mask_ram.sv =====
// Single-port synchronous memory holding one occupancy mask byte per cell.
// Read data is registered. Depends on oog_pkg.
module oog_mask_ram import oog_pkg::*; #(
  parameter int DEPTH = OOG_MAX_DIM * OOG_MAX_DIM * OOG_MAX_DIM,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [MASK_W-1:0] wdata_i,
  output logic [MASK_W-1:0] rdata_o
);

  logic [MASK_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ===== tb/oog_tb_pkg.sv =====
`timescale 1ns / 100ps
// Shadow model and result checker for the octant occupancy grid testbench.
// Depends on oog_pkg for the item structs, opcodes and register indexes.
package oog_tb_pkg;
  import oog_pkg::*;

  localparam int GRID_CELLS = OOG_MAX_DIM * OOG_MAX_DIM * OOG_MAX_DIM;

  class grid_shadow;
    logic [MASK_W-1:0] cell_masks [GRID_CELLS];
    logic [SIZE_W-1:0] axis_size [3];
    logic [INV_W-1:0]  inv_half;
    out_item_t         awaited_results [$];
    int                mismatches;

    function new();
      foreach (cell_masks[a]) cell_masks[a] = '0;
      axis_size = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
      inv_half = INV_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e sel, logic [CFG_DATA_W-1:0] data);
      case (sel)
        REG_SIZE_I:   axis_size[0] = data[SIZE_W-1:0];
        REG_SIZE_J:   axis_size[1] = data[SIZE_W-1:0];
        REG_SIZE_K:   axis_size[2] = data[SIZE_W-1:0];
        REG_INV_HALF: inv_half = data[INV_W-1:0];
        default: ;
      endcase
    endfunction

    // Cells in use along one axis; larger settings saturate at the grid size.
    function int unsigned span(int axis);
      return (axis_size[axis] > OOG_MAX_DIM) ? OOG_MAX_DIM : axis_size[axis];
    endfunction

    // Full-width product, truncated; a huge position never wraps into range.
    function logic [63:0] to_subcell(logic [POS_W-1:0] pos);
      logic [63:0] prod;
      prod = 64'(pos) * 64'(inv_half);
      return prod >> (OOG_POS_FRAC_BITS + INV_FRAC_BITS);
    endfunction

    function bit subs_inside(logic [63:0] si, logic [63:0] sj, logic [63:0] sk);
      return si < 2 * span(0) && sj < 2 * span(1) && sk < 2 * span(2);
    endfunction

    function int unsigned cell_at(logic [63:0] ci, logic [63:0] cj, logic [63:0] ck);
      return int'(((ci * OOG_MAX_DIM + cj) * OOG_MAX_DIM + ck) % GRID_CELLS);
    endfunction

    function logic [MASK_W-1:0] octant(logic [63:0] si, logic [63:0] sj, logic [63:0] sk);
      return MASK_W'(1) << {sk[0], sj[0], si[0]};
    endfunction

    // Applies one accepted command to the shadow grid and queues its result.
    function void note_command(in_item_t cmd);
      out_item_t   res;
      logic [63:0] si, sj, sk;
      int unsigned a;
      res = '0;
      case (opcode_e'(cmd.opcode)) inside
        OP_CLEAR: foreach (cell_masks[c]) cell_masks[c] = '0;
        OP_MARK_POS, OP_TEST_POS: begin
          si = to_subcell(cmd.pos_x);
          sj = to_subcell(cmd.pos_y);
          sk = to_subcell(cmd.pos_z);
          if (!subs_inside(si, sj, sk)) begin
            res.out_of_range = 1'b1;
          end else begin
            a = cell_at(si >> 1, sj >> 1, sk >> 1);
            if (cmd.opcode == OP_MARK_POS) cell_masks[a] |= octant(si, sj, sk);
            else res.subcell_set = |(cell_masks[a] & octant(si, sj, sk));
          end
        end
        OP_TEST_SUB: begin
          si = 64'(cmd.idx_i);
          sj = 64'(cmd.idx_j);
          sk = 64'(cmd.idx_k);
          if (!subs_inside(si, sj, sk)) begin
            res.out_of_range = 1'b1;
          end else begin
            a = cell_at(si >> 1, sj >> 1, sk >> 1);
            res.subcell_set = |(cell_masks[a] & octant(si, sj, sk));
          end
        end
        OP_READ_MASK: begin
          if (cmd.idx_i < span(0) && cmd.idx_j < span(1) && cmd.idx_k < span(2))
            res.cell_mask = cell_masks[cell_at(cmd.idx_i, cmd.idx_j, cmd.idx_k)];
          else
            res.out_of_range = 1'b1;
        end
        default: ;
      endcase
      awaited_results.push_back(res);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result mask %02h set %0b oor %0b",
                         got.cell_mask, got.subcell_set, got.out_of_range));
        return;
      end
      want = awaited_results.pop_front();
      if (got.cell_mask !== want.cell_mask)
        report($sformatf("cell_mask %02h, expected %02h", got.cell_mask, want.cell_mask));
      if (got.subcell_set !== want.subcell_set)
        report($sformatf("subcell_set %0b, expected %0b", got.subcell_set, want.subcell_set));
      if (got.out_of_range !== want.out_of_range)
        report($sformatf("out_of_range %0b, expected %0b",
                         got.out_of_range, want.out_of_range));
    endtask
  endclass

endpackage

// ===== tb/tb_octant_occupancy_grid_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for octant_occupancy_grid_unit: directed commands,
// then randomized phases under changing grid settings. Depends on oog_pkg and oog_tb_pkg.
module tb_octant_occupancy_grid_unit;
  import oog_pkg::*;
  import oog_tb_pkg::*;

  // Reset and each clear sweep pass over all MAX_DIM^3 cells, three sweeps in all.
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 84;
  localparam int MAX_IDLE      = 18;
  localparam int SETTLE_CYCLES = 8;
  localparam int MARK_HISTORY  = 32;
  localparam int ITEM_W        = $bits(in_item_t);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_i = '0;
  logic                  res_strobe_o;
  out_item_t             res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  grid_shadow  shadow;
  int unsigned cycles = 0;
  bit          idling = 1'b0;
  // Recently marked positions, reused so that tests and reads hit set bits.
  in_item_t    marks [$];

  octant_occupancy_grid_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_i         (in_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // All sampling happens here, on values from before the edge. A result and
  // the next command can meet at one edge; the result always belongs to the
  // older command, which is already queued, so the order below is safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_strobe_o) shadow.check_result(res_o);
      if (start && !busy) shadow.note_command(in_i);
      if (cfg_valid_i && cfg_ready_o) shadow.write_reg(cfg_reg_e'(cfg_index_i), cfg_data_i);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_item_t random_item();
    return in_item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom}));
  endfunction

  function automatic in_item_t make_cmd(logic [OPCODE_W-1:0] op,
                                        logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                        logic [POS_W-1:0] z, logic [IDX_W-1:0] i,
                                        logic [IDX_W-1:0] j, logic [IDX_W-1:0] k);
    in_item_t c;
    c.opcode = op;
    c.pos_x  = x;
    c.pos_y  = y;
    c.pos_z  = z;
    c.idx_i  = i;
    c.idx_j  = j;
    c.idx_k  = k;
    return c;
  endfunction

  // A random position whose sub-cell index lies inside the current grid along
  // one axis. The reach is the limit over the reciprocal, rounded down and clipped
  // to the position range; scaling a random word into it keeps pos * inv below
  // the limit, so the truncated index stays in range.
  function automatic logic [POS_W-1:0] pos_inside(int axis);
    logic [63:0] reach;
    reach = (64'(2 * shadow.span(axis)) << (OOG_POS_FRAC_BITS + INV_FRAC_BITS))
            / shadow.inv_half;
    if (reach > 64'h1_0000_0000) reach = 64'h1_0000_0000;
    return POS_W'((64'($urandom) * reach) >> POS_W);
  endfunction

  // A random index below scale times the cells in use; an empty axis gets an
  // arbitrary index, which is out of range anyway.
  function automatic logic [IDX_W-1:0] idx_inside(int axis, int scale);
    if (shadow.span(axis) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(scale * shadow.span(axis) - 1));
  endfunction

  // Offers one command and holds it until the block takes it. While idling is
  // on, a random gap may follow, with junk on the command bus and start low.
  task automatic send_cmd(in_item_t c);
    start <= 1'b1;
    in_i  <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (idling && $urandom_range(2) == 0) begin
      start <= 1'b0;
      in_i  <= random_item();
      repeat ($urandom_range(MAX_IDLE, 1)) @(posedge clk_i);
    end
  endtask

  // Waits until every queued command has produced its result, then waits out a
  // settling time so that the block is surely idle before a register write. The
  // first edge lets the last accepted command reach the queue.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (shadow.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four registers back to back. With noisy set, the unused upper
  // bits of the size writes carry random garbage that must be ignored.
  task automatic apply_setting(int si, int sj, int sk, logic [INV_W-1:0] inv, bit noisy);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_DATA_W-1:0] junk;
    junk = noisy ? ($urandom & ~CFG_DATA_W'((1 << SIZE_W) - 1)) : '0;
    vals[REG_SIZE_I]   = junk | CFG_DATA_W'(si);
    vals[REG_SIZE_J]   = junk | CFG_DATA_W'(sj);
    vals[REG_SIZE_K]   = junk | CFG_DATA_W'(sk);
    vals[REG_INV_HALF] = CFG_DATA_W'(inv);
    for (int n = REG_SIZE_I; n <= REG_INV_HALF; n++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(n);
      cfg_data_i  <= vals[n];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    in_item_t         cmd;
    in_item_t         m;
    int               pick;
    int               clear_phase;
    int               clear_slot;
    int               sz [3];
    logic [INV_W-1:0] inv;
    logic [63:0]      si, sj, sk;

    shadow = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset setting: 64 cells per axis and a
    // reciprocal of 1.0, so the sub-cell index is the integer part of the
    // position. The first command waits out the clearing pass after reset.
    send_cmd(make_cmd(OP_READ_MASK, '0, '0, '0, '0, '0, '0));
    send_cmd(make_cmd(OP_MARK_POS, '0, '0, '0, '1, '1, '1));
    // Top sub-cell on x, odd on y, even on z: cell (63,0,1), octant 3.
    send_cmd(make_cmd(OP_MARK_POS, 32'h007F_FFFF, 32'h0001_8000, 32'h0002_0000, '0, '0, '0));
    send_cmd(make_cmd(OP_TEST_SUB, '0, '0, '0, 7'd0, 7'd0, 7'd0));
    send_cmd(make_cmd(OP_TEST_SUB, '1, '1, '1, 7'd1, 7'd0, 7'd0));
    send_cmd(make_cmd(OP_TEST_SUB, '0, '0, '0, 7'd127, 7'd1, 7'd2));
    send_cmd(make_cmd(OP_TEST_POS, 32'h007F_0000, 32'h0001_FFFF, 32'h0002_7FFF, '0, '0, '0));
    send_cmd(make_cmd(OP_READ_MASK, '0, '0, '0, 7'd63, 7'd0, 7'd1));
    // Cell indices just past the grid and at the field maximum.
    send_cmd(make_cmd(OP_READ_MASK, '0, '0, '0, 7'd64, 7'd0, 7'd0));
    send_cmd(make_cmd(OP_READ_MASK, '0, '0, '0, '1, '1, '1));
    // The first position past the last sub-cell, and the largest position.
    send_cmd(make_cmd(OP_MARK_POS, 32'h0080_0000, '0, '0, '0, '0, '0));
    send_cmd(make_cmd(OP_TEST_POS, '1, '1, '1, '1, '1, '1));
    // Opcodes above read mask do nothing and return all zero.
    for (int n = OP_READ_MASK + 1; n < 2 ** OPCODE_W; n++)
      send_cmd(make_cmd(OPCODE_W'(n), '1, '1, '1, '1, '1, '1));
    send_cmd(make_cmd(OP_CLEAR, '1, '1, '1, '1, '1, '1));
    send_cmd(make_cmd(OP_TEST_SUB, '0, '0, '0, 7'd127, 7'd1, 7'd2));
    drain();

    // One cell per axis and the largest reciprocal: raw positions 0 and 1
    // land in sub-cell 0, raw 2 in sub-cell 1, raw 3 already outside.
    apply_setting(1, 1, 1, '1, 1'b0);
    send_cmd(make_cmd(OP_MARK_POS, 32'd2, 32'd2, 32'd2, '0, '0, '0));
    send_cmd(make_cmd(OP_MARK_POS, 32'd3, 32'd0, 32'd0, '0, '0, '0));
    send_cmd(make_cmd(OP_TEST_SUB, '0, '0, '0, 7'd2, 7'd0, 7'd0));
    send_cmd(make_cmd(OP_READ_MASK, '0, '0, '0, 7'd0, 7'd0, 7'd0));
    send_cmd(make_cmd(OP_READ_MASK, '0, '0, '0, 7'd0, 7'd1, 7'd0));
    drain();

    // An empty first axis turns everything away, even with the smallest
    // reciprocal, which maps every position to sub-cell 0.
    apply_setting(0, 64, 64, 32'd1, 1'b0);
    send_cmd(make_cmd(OP_MARK_POS, '1, '1, '1, '0, '0, '0));
    send_cmd(make_cmd(OP_TEST_SUB, '0, '0, '0, 7'd0, 7'd0, 7'd0));
    drain();

    // Sizes beyond the grid saturate; the far corner must be reachable.
    apply_setting(100, 127, 65, INV_RESET, 1'b0);
    send_cmd(make_cmd(OP_MARK_POS, 32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, '0, '0, '0));
    send_cmd(make_cmd(OP_READ_MASK, '0, '0, '0, 7'd63, 7'd63, 7'd63));
    send_cmd(make_cmd(OP_READ_MASK, '0, '0, '0, 7'd64, 7'd63, 7'd63));
    drain();

    // Random phases, each under a fresh setting. One clear sweep lands at a
    // random point of an earlier phase; the last phase runs without gaps.
    clear_phase = $urandom_range(RANDOM_PHASES - 2);
    clear_slot  = $urandom_range(PHASE_ITEMS - 1);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      foreach (sz[a]) begin
        case ($urandom_range(9))
          0:       sz[a] = 1;
          1:       sz[a] = OOG_MAX_DIM;
          default: sz[a] = $urandom_range(OOG_MAX_DIM, 1);
        endcase
      end
      case ($urandom_range(7))
        0:       inv = INV_RESET;
        1:       inv = 32'd1;
        2:       inv = '1;
        3:       inv = $urandom | 32'd1;
        default: inv = $urandom_range(1 << 20, 1 << 13);
      endcase
      apply_setting(sz[0], sz[1], sz[2], inv, 1'b1);
      idling = (p != RANDOM_PHASES - 1) && ($urandom_range(3) != 0);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Unused fields keep random content, so every bit gets exercised.
        cmd  = random_item();
        pick = $urandom_range(99);
        if (p == clear_phase && n == clear_slot) begin
          cmd.opcode = OP_CLEAR;
          marks.delete();
        end else if (pick < 30) begin
          cmd.opcode = OP_MARK_POS;
          cmd.pos_x  = pos_inside(0);
          cmd.pos_y  = pos_inside(1);
          cmd.pos_z  = pos_inside(2);
          marks.push_back(cmd);
          if (marks.size() > MARK_HISTORY) void'(marks.pop_front());
        end else if (pick < 48) begin
          cmd.opcode = OP_TEST_POS;
          if (marks.size() != 0 && $urandom_range(2) != 0) begin
            m = marks[$urandom_range(marks.size() - 1)];
            cmd.pos_x = m.pos_x;
            cmd.pos_y = m.pos_y;
            cmd.pos_z = m.pos_z;
          end else begin
            cmd.pos_x = pos_inside(0);
            cmd.pos_y = pos_inside(1);
            cmd.pos_z = pos_inside(2);
          end
        end else if (pick < 78) begin
          // Sub-cell tests and mask reads, aimed at marked cells when possible.
          cmd.opcode = (pick < 63) ? OP_TEST_SUB : OP_READ_MASK;
          if (marks.size() != 0 && $urandom_range(2) != 0) begin
            m  = marks[$urandom_range(marks.size() - 1)];
            si = shadow.to_subcell(m.pos_x);
            sj = shadow.to_subcell(m.pos_y);
            sk = shadow.to_subcell(m.pos_z);
            if (cmd.opcode == OP_READ_MASK) begin
              si = si >> 1;
              sj = sj >> 1;
              sk = sk >> 1;
            end
            cmd.idx_i = si[IDX_W-1:0];
            cmd.idx_j = sj[IDX_W-1:0];
            cmd.idx_k = sk[IDX_W-1:0];
          end else begin
            cmd.idx_i = idx_inside(0, (cmd.opcode == OP_TEST_SUB) ? 2 : 1);
            cmd.idx_j = idx_inside(1, (cmd.opcode == OP_TEST_SUB) ? 2 : 1);
            cmd.idx_k = idx_inside(2, (cmd.opcode == OP_TEST_SUB) ? 2 : 1);
          end
        end else if (pick < 95) begin
          // Real opcodes with fully random fields, mostly out of range.
          cmd.opcode = OPCODE_W'($urandom_range(OP_READ_MASK, OP_MARK_POS));
        end else begin
          cmd.opcode = OPCODE_W'($urandom_range(2 ** OPCODE_W - 1, OP_READ_MASK + 1));
        end
        send_cmd(cmd);
      end
      drain();
    end

    if (shadow.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/oog_pkg.sv
rtl/core/oog_mask_ram.sv
rtl/core/octant_occupancy_grid_unit.sv
tb/oog_tb_pkg.sv
tb/tb_octant_occupancy_grid_unit.sv
